@@ rtl/srp_pkg.sv @@
// Shared types and constants for the speed ramp profile sequencer.
// Used by srp_table, srp_ctrl and the top level; depends on nothing.
package srp_pkg;

    localparam int MAX_STEPS_DEF = 64;

    localparam logic [6:0]  STEP_COUNT_RST = 7'd1;
    localparam logic [15:0] TPS_RST        = 16'd1000;
    localparam logic [15:0] MIN_SPEED_RST  = 16'd10000;
    localparam logic [13:0] SEC_MAX        = 14'h3FFF;

    localparam logic [1:0] REG_STEP_COUNT = 2'd0;
    localparam logic [1:0] REG_TPS        = 2'd1;
    localparam logic [1:0] REG_MIN_SPEED  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } srp_op_t;

    typedef enum logic [2:0] {
        EV_RAMP  = 3'd0,
        EV_START = 3'd1,
        EV_END   = 3'd2,
        EV_ABORT = 3'd3,
        EV_STOP  = 3'd4
    } srp_event_t;

    typedef struct packed {
        logic [15:0] target;
        logic [13:0] period;
        logic [13:0] delta;
        logic [13:0] hold;
    } srp_entry_t;

    typedef struct packed {
        logic [6:0]  step_count;
        logic [15:0] ticks_per_second;
        logic [15:0] min_speed;
    } srp_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] speed;
        logic [5:0]  step_index;
        srp_event_t  event_res;
    } srp_result_t;

endpackage

@@ rtl/srp_table.sv @@
// Profile step table: one write port and two registered read ports.
// Port A returns the entry of the running step, port B the target of the step after it.
// Depends on srp_pkg.
module srp_table #(
    parameter int MAX_STEPS = srp_pkg::MAX_STEPS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_STEPS)-1:0] wr_addr,
    input  srp_pkg::srp_entry_t          wr_entry,
    input  logic [$clog2(MAX_STEPS)-1:0] rd_addr,
    output srp_pkg::srp_entry_t          cur_entry,
    output logic [15:0]                  nxt_target,
    output logic [15:0]                  first_target
);
    import srp_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS);

    srp_entry_t        table_mem [MAX_STEPS];
    logic [STEP_W-1:0] rd_b_addr;
    srp_entry_t        rd_a_reg;
    logic [15:0]       rd_b_reg;
    srp_entry_t        wr_data_reg;
    logic              hit_a_reg;
    logic              hit_b_reg;
    logic [15:0]       first_target_reg;

    assign rd_b_addr = (rd_addr == STEP_W'(MAX_STEPS - 1)) ? '0 : rd_addr + STEP_W'(1);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_entry;
        end
        rd_a_reg    <= table_mem[rd_addr];
        rd_b_reg    <= table_mem[rd_b_addr].target;
        wr_data_reg <= wr_entry;
        // Step 0's target is kept aside so that a start needs no read.
        if (wr_en && (wr_addr == '0)) begin
            first_target_reg <= wr_entry.target;
        end
    end

    // A write that lands on an address being read returns the old word, so
    // the written data is forwarded in place of the read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else begin
            hit_a_reg <= wr_en && (wr_addr == rd_addr);
            hit_b_reg <= wr_en && (wr_addr == rd_b_addr);
        end
    end

    assign cur_entry    = hit_a_reg ? wr_data_reg : rd_a_reg;
    assign nxt_target   = hit_b_reg ? wr_data_reg.target : rd_b_reg;
    assign first_target = first_target_reg;

endmodule

@@ rtl/srp_ctrl.sv @@
// Sequencer state and per-request update: ramp, hold, advance, start and stop.
// Reads the step table through srp_table and steers its read address; depends on srp_pkg.
module srp_ctrl #(
    parameter int MAX_STEPS = srp_pkg::MAX_STEPS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  srp_pkg::srp_op_t             op,
    input  srp_pkg::srp_cfg_t            cfg,
    input  srp_pkg::srp_entry_t          cur_entry,
    input  logic [15:0]                  nxt_target,
    input  logic [15:0]                  first_target,
    output logic [$clog2(MAX_STEPS)-1:0] rd_addr,
    output srp_pkg::srp_result_t         result
);
    import srp_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam int LIM_W  = (STEP_W + 1 > 7) ? STEP_W + 1 : 7;
    localparam int IDX_W  = (STEP_W > 6) ? STEP_W : 6;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RAMP,
        PH_HOLD
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [15:0]       cmd_reg, cmd_next;
    logic [15:0]       goal_reg, goal_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       tick_reg, tick_next;
    logic [13:0]       sec_reg, sec_next;

    logic [13:0]       period_eff;
    logic [15:0]       tps_eff;
    logic [16:0]       tick_inc;
    logic [16:0]       up_sum;
    logic [15:0]       up_val;
    logic [15:0]       down_diff;
    logic [15:0]       down_val;
    logic [15:0]       ramp_val;
    logic [13:0]       sec_inc;
    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  step_plus;
    logic [IDX_W-1:0]  step_ext;

    assign period_eff = (cur_entry.period == '0) ? 14'd1 : cur_entry.period;
    assign tps_eff    = (cfg.ticks_per_second == '0) ? 16'd1 : cfg.ticks_per_second;
    assign tick_inc   = {1'b0, tick_reg} + 17'd1;

    // Ramp arithmetic: move toward the goal by delta and clamp at the goal.
    assign up_sum    = {1'b0, cmd_reg} + 17'(cur_entry.delta);
    assign up_val    = (up_sum > {1'b0, goal_reg}) ? goal_reg : up_sum[15:0];
    assign down_diff = cmd_reg - goal_reg;
    assign down_val  = (down_diff <= 16'(cur_entry.delta)) ? goal_reg
                                                            : cmd_reg - 16'(cur_entry.delta);
    assign ramp_val  = (cmd_reg < goal_reg) ? up_val :
                       (cmd_reg > goal_reg) ? down_val : cmd_reg;

    assign limit     = (LIM_W'(cfg.step_count) > LIM_W'(MAX_STEPS)) ? LIM_W'(MAX_STEPS)
                                                                     : LIM_W'(cfg.step_count);
    assign step_plus = LIM_W'(step_reg) + LIM_W'(1);
    assign step_ext  = IDX_W'(step_reg);

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        goal_next  = goal_reg;
        step_next  = step_reg;
        tick_next  = tick_reg;
        sec_next   = sec_reg;
        sec_inc    = sec_reg;
        result     = '{valid: 1'b0, speed: '0, step_index: step_ext[5:0], event_res: EV_RAMP};

        if (fire) begin
            unique case (op)
                OP_TICK: begin
                    unique case (phase_reg)
                        PH_RAMP: begin
                            if (tick_inc < 17'(period_eff)) begin
                                tick_next = tick_inc[15:0];
                            end else begin
                                tick_next = '0;
                                if (ramp_val < cfg.min_speed) begin
                                    phase_next       = PH_IDLE;
                                    cmd_next         = '0;
                                    goal_next        = '0;
                                    sec_next         = '0;
                                    result.valid     = 1'b1;
                                    result.event_res = EV_ABORT;
                                end else begin
                                    cmd_next = ramp_val;
                                    if (ramp_val == goal_reg) begin
                                        phase_next = PH_HOLD;
                                        sec_next   = '0;
                                    end
                                    result.valid     = 1'b1;
                                    result.speed     = ramp_val;
                                    result.event_res = EV_RAMP;
                                end
                            end
                        end
                        PH_HOLD: begin
                            if (tick_inc >= 17'(tps_eff)) begin
                                tick_next = '0;
                                if (sec_reg < SEC_MAX) begin
                                    sec_inc = sec_reg + 14'd1;
                                end
                            end else begin
                                tick_next = tick_inc[15:0];
                            end
                            sec_next = sec_inc;
                            if (sec_inc >= cur_entry.hold) begin
                                tick_next = '0;
                                sec_next  = '0;
                                if (step_plus >= limit) begin
                                    phase_next       = PH_IDLE;
                                    cmd_next         = '0;
                                    goal_next        = '0;
                                    result.valid     = 1'b1;
                                    result.event_res = EV_END;
                                end else begin
                                    step_next  = step_plus[STEP_W-1:0];
                                    goal_next  = nxt_target;
                                    phase_next = (cmd_reg == nxt_target) ? PH_HOLD : PH_RAMP;
                                end
                            end
                        end
                        default: begin
                            // Ticks while idle are dropped.
                        end
                    endcase
                end
                OP_LOAD: begin
                    // The table write is issued by the top level.
                end
                OP_START: begin
                    step_next        = '0;
                    cmd_next         = first_target;
                    goal_next        = first_target;
                    phase_next       = PH_HOLD;
                    tick_next        = '0;
                    sec_next         = '0;
                    result.valid     = 1'b1;
                    result.speed     = first_target;
                    result.step_index = '0;
                    result.event_res = EV_START;
                end
                OP_STOP: begin
                    phase_next       = PH_IDLE;
                    cmd_next         = '0;
                    goal_next        = '0;
                    tick_next        = '0;
                    sec_next         = '0;
                    result.valid     = 1'b1;
                    result.event_res = EV_STOP;
                end
                default: begin
                end
            endcase
        end
    end

    // The table is read at the step this update leaves behind, so the entry is
    // ready for the request in the next cycle.
    assign rd_addr = step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            goal_reg  <= '0;
            step_reg  <= '0;
            tick_reg  <= '0;
            sec_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            goal_reg  <= goal_next;
            step_reg  <= step_next;
            tick_reg  <= tick_next;
            sec_reg   <= sec_next;
        end
    end

endmodule

@@ rtl/speed_ramp_profile_sequencer.sv @@
// Speed ramp profile sequencer: a request that yields a result has it in the next cycle,
// held in an output register; s_ready is high while that register is empty or being taken,
// so a request enters every cycle unless a held result stalls it. The rate is set by the
// two-port step table, whose registered reads follow the next step so no request waits on a read.
// Reset (aresetn, synchronous, active low) clears the sequencer to idle, sets the registers
// to their defaults and empties the output; table contents stay undefined until loaded.
module speed_ramp_profile_sequencer #(
    parameter int MAX_STEPS = srp_pkg::MAX_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [5:0]  s_entry_index,
    input  logic [15:0] s_entry_target,
    input  logic [13:0] s_entry_period,
    input  logic [13:0] s_entry_delta,
    input  logic [13:0] s_entry_hold,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_speed,
    output logic [5:0]  m_step_index,
    output logic [2:0]  m_event_res
);
    import srp_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS);

    srp_cfg_t          cfg_reg;
    logic              fire;
    srp_op_t           op;
    logic              wr_en;
    srp_entry_t        wr_entry;
    logic [STEP_W-1:0] rd_addr;
    srp_entry_t        cur_entry;
    logic [15:0]       nxt_target;
    logic [15:0]       first_target;
    srp_result_t       result;
    logic              m_valid_reg;
    logic [15:0]       m_speed_reg;
    logic [5:0]        m_step_reg;
    logic [2:0]        m_event_reg;

    assign s_ready  = !m_valid_reg || m_ready;
    assign fire     = s_valid && s_ready;
    assign op       = srp_op_t'(s_op);
    assign wr_en    = fire && (op == OP_LOAD) && (32'(s_entry_index) < MAX_STEPS);
    assign wr_entry = '{target: s_entry_target, period: s_entry_period,
                        delta: s_entry_delta, hold: s_entry_hold};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{step_count: STEP_COUNT_RST, ticks_per_second: TPS_RST,
                         min_speed: MIN_SPEED_RST};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP_COUNT: cfg_reg.step_count       <= cfg_wdata[6:0];
                REG_TPS:        cfg_reg.ticks_per_second <= cfg_wdata;
                REG_MIN_SPEED:  cfg_reg.min_speed        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    srp_table #(
        .MAX_STEPS(MAX_STEPS)
    ) u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (wr_en),
        .wr_addr      (STEP_W'(s_entry_index)),
        .wr_entry     (wr_entry),
        .rd_addr      (rd_addr),
        .cur_entry    (cur_entry),
        .nxt_target   (nxt_target),
        .first_target (first_target)
    );

    srp_ctrl #(
        .MAX_STEPS(MAX_STEPS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .op           (op),
        .cfg          (cfg_reg),
        .cur_entry    (cur_entry),
        .nxt_target   (nxt_target),
        .first_target (first_target),
        .rd_addr      (rd_addr),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && result.valid) begin
            m_speed_reg <= result.speed;
            m_step_reg  <= result.step_index;
            m_event_reg <= result.event_res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_speed      = m_speed_reg;
    assign m_step_index = m_step_reg;
    assign m_event_res  = m_event_reg;

    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (op == OP_START) |=> m_valid && (m_event_res == EV_START)
                                     && (m_step_index == '0))
        else $error("start request did not produce a start result");

    a_stop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (op == OP_STOP) |=> m_valid && (m_event_res == EV_STOP) && (m_speed == '0))
        else $error("stop request did not command speed zero");

    a_zero_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_END || m_event_res == EV_ABORT) |-> (m_speed == '0))
        else $error("profile end or abort with nonzero speed");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (op == OP_LOAD) && !m_valid |=> !m_valid)
        else $error("table load produced a result");

endmodule
